// ===== src/c2e_pkg.sv =====
`default_nettype none

package c2e_pkg;

    localparam int unsigned YEAR_W   = 8;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 6;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned SECOND_W = 6;
    localparam int unsigned EPOCH_W  = 32;
    localparam int unsigned DAYS_W   = 16;
    localparam int unsigned YDAY_W   = 9;

    // Year limits as offsets from 1900
    localparam logic [YEAR_W-1:0] MIN_YEAR_OFS   = 8'd98;
    localparam logic [YEAR_W-1:0] MAX_YEAR_OFS   = 8'd199;
    localparam logic [YEAR_W-1:0] EPOCH_YEAR_OFS = 8'd70;
    // Leap years in 1970..y-1 are (y_ofs - 69) / 4 over the accepted range
    localparam logic [YEAR_W-1:0] LEAP_BASE_OFS  = 8'd69;

    localparam logic [MONTH_W-1:0]  MAX_MONTH  = 4'd12;
    localparam logic [DAY_W-1:0]    MAX_DAY    = 6'd31;
    localparam logic [HOUR_W-1:0]   MAX_HOUR   = 5'd23;
    localparam logic [MINUTE_W-1:0] MAX_MINUTE = 6'd59;
    localparam logic [SECOND_W-1:0] MAX_SECOND = 6'd59;

    localparam logic [DAYS_W-1:0]  DAYS_PER_YEAR   = 16'd365;
    localparam logic [EPOCH_W-1:0] SECS_PER_MINUTE = 32'd60;
    localparam logic [EPOCH_W-1:0] SECS_PER_HOUR   = 32'd3600;
    localparam logic [EPOCH_W-1:0] SECS_PER_DAY    = 32'd86400;
    localparam logic [EPOCH_W-1:0] MAX_EPOCH       = 32'd4102444799;

    typedef struct packed {
        logic [YEAR_W-1:0]   years_since_1900;
        logic [MONTH_W-1:0]  month_number;
        logic [DAY_W-1:0]    day_of_month;
        logic [HOUR_W-1:0]   hour_of_day;
        logic [MINUTE_W-1:0] minute_of_hour;
        logic [SECOND_W-1:0] second_of_minute;
    } t_reading;

    function automatic logic [YDAY_W-1:0] days_before_month(
        input logic [MONTH_W-1:0] month,
        input logic               leap
    );
        logic [YDAY_W-1:0] base;
        base = '0;
        unique case (month)
            4'd1:    base = 9'd0;
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && (month > 4'd2)) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

`default_nettype wire

// ===== src/c2e_check.sv =====
`default_nettype none

module c2e_check (
    input  wire c2e_pkg::t_reading i_reading,
    output logic                   o_ok
);

    always_comb begin
        o_ok = (i_reading.years_since_1900 >= c2e_pkg::MIN_YEAR_OFS)
            && (i_reading.years_since_1900 <= c2e_pkg::MAX_YEAR_OFS)
            && (i_reading.month_number != '0)
            && (i_reading.month_number <= c2e_pkg::MAX_MONTH)
            && (i_reading.day_of_month != '0)
            && (i_reading.day_of_month <= c2e_pkg::MAX_DAY)
            && (i_reading.hour_of_day <= c2e_pkg::MAX_HOUR)
            && (i_reading.minute_of_hour <= c2e_pkg::MAX_MINUTE)
            && (i_reading.second_of_minute <= c2e_pkg::MAX_SECOND);
    end

endmodule

`default_nettype wire

// ===== src/c2e_conv.sv =====
`default_nettype none

module c2e_conv (
    input  wire c2e_pkg::t_reading                 i_reading,
    input  wire                                    i_ok,
    output logic [c2e_pkg::EPOCH_W-1:0]            o_epoch_seconds
);

    logic [c2e_pkg::YEAR_W-1:0]  year_ofs;
    logic [c2e_pkg::YEAR_W-1:0]  leap_ofs;
    logic [c2e_pkg::YEAR_W-3:0]  leaps;
    logic                        leap;
    logic [c2e_pkg::YDAY_W-1:0]  yday;
    logic [c2e_pkg::DAYS_W-1:0]  days;
    logic [c2e_pkg::EPOCH_W-1:0] secs;

    always_comb begin
        year_ofs = i_reading.years_since_1900 - c2e_pkg::EPOCH_YEAR_OFS;
        leap_ofs = i_reading.years_since_1900 - c2e_pkg::LEAP_BASE_OFS;
        leaps    = leap_ofs[c2e_pkg::YEAR_W-1:2];
        // 1900 is a multiple of four and 2100 lies outside the range
        leap     = (i_reading.years_since_1900[1:0] == 2'b00);
        yday     = c2e_pkg::days_before_month(i_reading.month_number, leap);

        days = c2e_pkg::DAYS_W'(c2e_pkg::DAYS_W'(year_ofs) * c2e_pkg::DAYS_PER_YEAR)
             + c2e_pkg::DAYS_W'(leaps)
             + c2e_pkg::DAYS_W'(yday)
             + c2e_pkg::DAYS_W'(i_reading.day_of_month)
             - c2e_pkg::DAYS_W'(1);

        secs = c2e_pkg::EPOCH_W'(c2e_pkg::EPOCH_W'(days) * c2e_pkg::SECS_PER_DAY)
             + c2e_pkg::EPOCH_W'(c2e_pkg::EPOCH_W'(i_reading.hour_of_day)
                                 * c2e_pkg::SECS_PER_HOUR)
             + c2e_pkg::EPOCH_W'(c2e_pkg::EPOCH_W'(i_reading.minute_of_hour)
                                 * c2e_pkg::SECS_PER_MINUTE)
             + c2e_pkg::EPOCH_W'(i_reading.second_of_minute);

        o_epoch_seconds = i_ok ? secs : '0;
    end

endmodule

`default_nettype wire

// ===== src/calendar_to_epoch_seconds_top.sv =====
// Calendar reading to seconds since 1970-01-01 00:00:00 UTC.
// Input channel: i_valid / o_ready with the six reading fields (year as an
// offset from 1900, month, day, hour, minute, second). Output channel:
// o_valid / i_ready with o_epoch_seconds and o_reading_valid.
// Each input transaction gives exactly one output transaction, in order.
// Readings failing a range check (year 1998..2099, month 1..12, day 1..31,
// hour 0..23, minute and second 0..59) give zero with o_reading_valid low.
// Day is not checked against its month length; excess days run on.
// Pipeline: the reading passes the input register, then the result
// register, whose output drives o_valid. Throughput: one transaction per
// cycle while the receiver does not stall, set by the single conversion
// pass between the two registers.
// When the receiver stalls, the result register holds; the input register,
// if empty, still takes one more reading, after which o_ready falls until
// the output drains.
// Reset (synchronous, active low) empties both registers; no clearing pass.
`default_nettype none

module calendar_to_epoch_seconds_top (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_ready,
    input  wire  [c2e_pkg::YEAR_W-1:0]         i_years_since_1900,
    input  wire  [c2e_pkg::MONTH_W-1:0]        i_month_number,
    input  wire  [c2e_pkg::DAY_W-1:0]          i_day_of_month,
    input  wire  [c2e_pkg::HOUR_W-1:0]         i_hour_of_day,
    input  wire  [c2e_pkg::MINUTE_W-1:0]       i_minute_of_hour,
    input  wire  [c2e_pkg::SECOND_W-1:0]       i_second_of_minute,
    output logic                               o_valid,
    input  wire                                i_ready,
    output logic [c2e_pkg::EPOCH_W-1:0]        o_epoch_seconds,
    output logic                               o_reading_valid
);

    logic                         r_s1_valid;
    c2e_pkg::t_reading            r_s1_reading;
    logic                         r_out_valid;
    logic [c2e_pkg::EPOCH_W-1:0]  r_epoch;
    logic                         r_ok;

    logic                         out_free;
    logic                         s1_free;
    logic                         ok;
    logic [c2e_pkg::EPOCH_W-1:0]  epoch;
    c2e_pkg::t_reading            n_s1_reading;

    assign out_free = !r_out_valid || i_ready;
    assign s1_free  = !r_s1_valid || out_free;
    assign o_ready  = s1_free;
    assign o_valid  = r_out_valid;
    assign o_epoch_seconds = r_epoch;
    assign o_reading_valid = r_ok;

    always_comb begin
        n_s1_reading.years_since_1900 = i_years_since_1900;
        n_s1_reading.month_number     = i_month_number;
        n_s1_reading.day_of_month     = i_day_of_month;
        n_s1_reading.hour_of_day      = i_hour_of_day;
        n_s1_reading.minute_of_hour   = i_minute_of_hour;
        n_s1_reading.second_of_minute = i_second_of_minute;
    end

    c2e_check u_check (
        .i_reading (r_s1_reading),
        .o_ok      (ok)
    );

    c2e_conv u_conv (
        .i_reading       (r_s1_reading),
        .i_ok            (ok),
        .o_epoch_seconds (epoch)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free && i_valid) begin
            r_s1_reading <= n_s1_reading;
        end
        if (out_free && r_s1_valid) begin
            r_epoch <= epoch;
            r_ok    <= ok;
        end
    end

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_reading_valid) |-> (o_epoch_seconds == '0))
        else $error("invalid reading with nonzero seconds");

    a_max_epoch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_epoch_seconds <= c2e_pkg::MAX_EPOCH))
        else $error("seconds beyond 2099-12-31 23:59:59");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_ready) |=> r_s1_valid)
        else $error("input stage dropped a reading under stall");

    a_s1_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && out_free) |=> r_out_valid)
        else $error("reading lost between stages");

endmodule

`default_nettype wire
